>>> src/ithb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ithb_pkg
// Shared types, field constants and the checksum fold for the IPv4/TCP header
// builder.
// ----------------------------------------------------------------------------
package ithb_pkg;

   localparam int HdrWords = 20;
   localparam int IdxWidth = 5;
   localparam int CsrIdxWidth = 8;

   localparam logic [IdxWidth-1:0] LastIdx = 5'd19;

   localparam logic [15:0] VerIhlTos  = 16'h4500;
   localparam logic [15:0] TotalLen   = 16'd40;
   localparam logic [15:0] FragWord   = 16'h0000;
   localparam logic [7:0]  TimeToLive = 8'd128;
   localparam logic [7:0]  ProtoTcp   = 8'd6;
   localparam logic [15:0] TcpLen     = 16'd20;
   localparam logic [3:0]  DataOffset = 4'd5;
   localparam logic [15:0] WindowSize = 16'hFFFF;
   localparam logic [15:0] UrgentPtr  = 16'h0000;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_SRC_ADDR  = 8'd0,
      REG_DST_ADDR  = 8'd1,
      REG_SRC_PORT  = 8'd2,
      REG_DEST_PORT = 8'd3
   } csr_idx_type;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dest_port;
   } cfg_type;

   typedef struct packed {
      logic [31:0] ack_base;
      logic [31:0] sequence_number;
      logic [15:0] ip_ident;
      logic [5:0]  flags;   // {urg, ack, psh, rst, syn, fin}
   } req_type;

   typedef logic [HdrWords-1:0][15:0] hdr_type;

   // Folds the end-around carries of a ones'-complement sum and inverts it.
   function automatic logic [15:0] csum_fold(input logic [20:0] sum);
      logic [16:0] s1;
      logic [15:0] s2;
      s1 = 17'(sum[15:0]) + 17'(sum[20:16]);
      s2 = s1[15:0] + 16'(s1[16]);
      return ~s2;
   endfunction

endpackage

>>> src/ipv4_tcp_header_builder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_tcp_header_builder_unit
// Builds a 40-byte IPv4 plus TCP header with both checksums for each request
// and streams it out as twenty 16-bit words.
// ----------------------------------------------------------------------------
// Each request word produces twenty result words, header word 0 first, in
// network byte order, with the word position on rsp_tuser and rsp_tlast on
// word 19. The result port moves one 16-bit word per cycle while rsp_tready stays
// high. A request passes the input register, then the header buffer, then the
// output register; the next request is taken while the current header drains,
// and its header is loaded in the cycle its predecessor's last word leaves the
// buffer. Addresses and ports come from the csr registers, which the user must
// write only while no request is in flight; the block does not enforce this.
// Writes to unused indexes are dropped.
module ipv4_tcp_header_builder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] fin, [1] syn, [2] rst, [3] psh, [4] ack, [5] urg, [21:6] ip_ident,
   // [53:22] sequence_number, [85:54] ack_base, [87:86] zero
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] header_word
   output logic [4:0]  rsp_tuser,   // [4:0] word_index
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);
   import ithb_pkg::*;

   cfg_type cfg_ff;
   req_type req_ff;
   logic    req_valid_ff, req_valid_in;
   hdr_type hdr;
   logic    hdr_ready;
   logic    req_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            REG_SRC_ADDR:  cfg_ff.src_addr  <= csr_data;
            REG_DST_ADDR:  cfg_ff.dst_addr  <= csr_data;
            REG_SRC_PORT:  cfg_ff.src_port  <= csr_data[15:0];
            REG_DEST_PORT: cfg_ff.dest_port <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      req_tready   = !req_valid_ff || hdr_ready;
      req_take     = req_tvalid && req_tready;
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (hdr_ready) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.flags           <= req_tdata[5:0];
         req_ff.ip_ident        <= req_tdata[21:6];
         req_ff.sequence_number <= req_tdata[53:22];
         req_ff.ack_base        <= req_tdata[85:54];
      end
   end

   ithb_hdr_calc u_calc (
      .req (req_ff),
      .cfg (cfg_ff),
      .hdr (hdr)
   );

   ithb_serializer u_ser (
      .clock      (clock),
      .reset      (reset),
      .hdr_valid  (req_valid_ff),
      .hdr        (hdr),
      .hdr_ready  (hdr_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> src/ithb_hdr_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ithb_hdr_calc
// Builds all twenty header words of one request, including both checksums.
// ----------------------------------------------------------------------------
module ithb_hdr_calc (
   input  ithb_pkg::req_type req,
   input  ithb_pkg::cfg_type cfg,
   output ithb_pkg::hdr_type hdr
);
   import ithb_pkg::*;

   logic [31:0] ack_value;
   logic [15:0] flag_word;
   logic [20:0] ip_sum;
   logic [20:0] tcp_sum;

   always_comb begin
      ack_value = (req.ack_base != 32'd0) ? req.ack_base + 32'd1 : 32'd0;
      flag_word = {DataOffset, 6'd0, req.flags};

      ip_sum = 21'(VerIhlTos) + 21'(TotalLen) + 21'(req.ip_ident) + 21'(FragWord)
             + 21'({TimeToLive, ProtoTcp})
             + 21'(cfg.src_addr[31:16]) + 21'(cfg.src_addr[15:0])
             + 21'(cfg.dst_addr[31:16]) + 21'(cfg.dst_addr[15:0]);

      // Pseudo-header (addresses, protocol, TCP length) plus the TCP header.
      tcp_sum = 21'(cfg.src_addr[31:16]) + 21'(cfg.src_addr[15:0])
              + 21'(cfg.dst_addr[31:16]) + 21'(cfg.dst_addr[15:0])
              + 21'(ProtoTcp) + 21'(TcpLen)
              + 21'(cfg.src_port) + 21'(cfg.dest_port)
              + 21'(req.sequence_number[31:16]) + 21'(req.sequence_number[15:0])
              + 21'(ack_value[31:16]) + 21'(ack_value[15:0])
              + 21'(flag_word) + 21'(WindowSize) + 21'(UrgentPtr);

      hdr[0]  = VerIhlTos;
      hdr[1]  = TotalLen;
      hdr[2]  = req.ip_ident;
      hdr[3]  = FragWord;
      hdr[4]  = {TimeToLive, ProtoTcp};
      hdr[5]  = csum_fold(ip_sum);
      hdr[6]  = cfg.src_addr[31:16];
      hdr[7]  = cfg.src_addr[15:0];
      hdr[8]  = cfg.dst_addr[31:16];
      hdr[9]  = cfg.dst_addr[15:0];
      hdr[10] = cfg.src_port;
      hdr[11] = cfg.dest_port;
      hdr[12] = req.sequence_number[31:16];
      hdr[13] = req.sequence_number[15:0];
      hdr[14] = ack_value[31:16];
      hdr[15] = ack_value[15:0];
      hdr[16] = flag_word;
      hdr[17] = WindowSize;
      hdr[18] = csum_fold(tcp_sum);
      hdr[19] = UrgentPtr;
   end

endmodule

>>> src/ithb_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ithb_serializer
// Holds one finished header and sends it out one word per cycle, while rsp_tready
// is high, through a registered output stage.
// ----------------------------------------------------------------------------
module ithb_serializer (
   input  logic              clock,
   input  logic              reset,
   input  logic              hdr_valid,
   input  ithb_pkg::hdr_type hdr,
   output logic              hdr_ready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,
   output logic [4:0]        rsp_tuser,
   output logic              rsp_tlast
);
   import ithb_pkg::*;

   hdr_type             buf_ff;
   logic                buf_valid_ff, buf_valid_in;
   logic [IdxWidth-1:0] idx_ff, idx_in;
   logic                out_valid_ff, out_valid_in;
   logic [15:0]         out_word_ff;
   logic [IdxWidth-1:0] out_idx_ff;
   logic                out_last_ff;
   logic                advance;
   logic                take_word;
   logic                buf_done;

   always_comb begin
      advance   = !out_valid_ff || rsp_tready;
      take_word = advance && buf_valid_ff;
      buf_done  = take_word && (idx_ff == LastIdx);
      hdr_ready = !buf_valid_ff || buf_done;

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = buf_valid_ff;
      end

      buf_valid_in = buf_valid_ff;
      idx_in       = idx_ff;
      if (take_word) begin
         idx_in = idx_ff + 5'd1;
      end
      if (buf_done) begin
         buf_valid_in = 1'b0;
         idx_in       = '0;
      end
      if (hdr_ready && hdr_valid) begin
         buf_valid_in = 1'b1;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hdr_ready && hdr_valid) begin
         buf_ff <= hdr;
      end
      if (take_word) begin
         out_word_ff <= buf_ff[idx_ff];
         out_idx_ff  <= idx_ff;
         out_last_ff <= (idx_ff == LastIdx);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_word_ff;
   assign rsp_tuser  = out_idx_ff;
   assign rsp_tlast  = out_last_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LastIdx)
      else $error("word counter ran past the last header word");

   a_last_marks_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_last_ff == (out_idx_ff == LastIdx)))
      else $error("last flag does not match the word position");

   a_words_in_order: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_tready && !out_last_ff)
         |=> (out_valid_ff && out_idx_ff == $past(out_idx_ff) + 5'd1))
      else $error("header words left the buffer out of order or with a gap");

endmodule

>>> test/ipv4_tcp_header_builder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_tcp_header_builder_unit_tb
// Drives header requests and csr writes into the IPv4/TCP header builder and
// checks every streamed header word against a fixed header or a local header and
// checksum predictor. A short directed table runs first, then three random phases
// with different amounts of idling on the request and response sides.
// ----------------------------------------------------------------------------
module ipv4_tcp_header_builder_unit_tb;
   import ithb_pkg::*;

   typedef enum bit {ROW_REQ, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [7:0]   csr_idx;
      logic [31:0]  csr_wdata;
      req_type      req;
      bit           known;
      hdr_type      hdr;
   } stim_row_type;

   typedef struct {
      logic [15:0]         word;
      logic [IdxWidth-1:0] idx;
      logic                last;
   } word_due_type;

   // Headers listed from word 19 down to word 0.
   // No request content and all registers at zero.
   localparam hdr_type HdrBare = {
      16'h0000, 16'hAFE5, 16'hFFFF, 16'h5000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h3AD1, 16'h8006, 16'h0000, 16'h0000, 16'h0028, 16'h4500};
   // Every flag, ident and sequence number at all ones, registers at zero.
   localparam hdr_type HdrAllOnes = {
      16'h0000, 16'hAFA6, 16'hFFFF, 16'h503F, 16'h0000, 16'h0000, 16'hFFFF,
      16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h3AD1, 16'h8006, 16'h0000, 16'hFFFF, 16'h0028, 16'h4500};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   cfg_type      shadow_cfg = '0;
   word_due_type words_due[$];
   stim_row_type stim_table[$];
   int           mismatches = 0;
   int           send_idle_pct = 11;
   int           recv_idle_pct = 87;

   ipv4_tcp_header_builder_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   function automatic logic [15:0] fold_invert(logic [31:0] acc);
      while (acc[31:16] != 16'd0) begin
         acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
      end
      return ~acc[15:0];
   endfunction

   function automatic hdr_type predict_header(cfg_type c, req_type r);
      hdr_type     h;
      logic [31:0] ack_field;
      logic [31:0] acc;
      ack_field = (r.ack_base != 32'd0) ? r.ack_base + 32'd1 : 32'd0;
      h[0]  = VerIhlTos;
      h[1]  = TotalLen;
      h[2]  = r.ip_ident;
      h[3]  = FragWord;
      h[4]  = {TimeToLive, ProtoTcp};
      h[5]  = 16'd0;
      h[6]  = c.src_addr[31:16];
      h[7]  = c.src_addr[15:0];
      h[8]  = c.dst_addr[31:16];
      h[9]  = c.dst_addr[15:0];
      h[10] = c.src_port;
      h[11] = c.dest_port;
      h[12] = r.sequence_number[31:16];
      h[13] = r.sequence_number[15:0];
      h[14] = ack_field[31:16];
      h[15] = ack_field[15:0];
      h[16] = {DataOffset, 6'd0, r.flags};
      h[17] = WindowSize;
      h[18] = 16'd0;
      h[19] = UrgentPtr;
      // The pseudo-header adds the protocol and the TCP length to the sum.
      acc = 32'(ProtoTcp) + 32'(TcpLen);
      for (int k = 6; k < 10; k++) acc += 32'(h[k]);
      for (int k = 10; k < HdrWords; k++) acc += 32'(h[k]);
      h[18] = fold_invert(acc);
      acc = '0;
      for (int k = 0; k < 10; k++) acc += 32'(h[k]);
      h[5] = fold_invert(acc);
      return h;
   endfunction

   function automatic void add_req(logic [5:0] flags, logic [15:0] ident,
                                   logic [31:0] seq, logic [31:0] ack_base);
      stim_row_type row;
      row = '{ROW_REQ, 8'd0, 32'd0, '{ack_base, seq, ident, flags}, 1'b0, '0};
      stim_table.push_back(row);
   endfunction

   function automatic void add_known(logic [5:0] flags, logic [15:0] ident,
                                     logic [31:0] seq, logic [31:0] ack_base,
                                     hdr_type hdr);
      stim_row_type row;
      row = '{ROW_REQ, 8'd0, 32'd0, '{ack_base, seq, ident, flags}, 1'b1, hdr};
      stim_table.push_back(row);
   endfunction

   function automatic void add_cfg(logic [7:0] idx, logic [31:0] wdata);
      stim_row_type row;
      row = '{ROW_CFG, idx, wdata, '0, 1'b0, '0};
      stim_table.push_back(row);
   endfunction

   function automatic logic [31:0] pick_cfg_value();
      case ($urandom_range(3))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic report_bad(string msg);
      if (mismatches < 10) $display("%s", msg);
      mismatches++;
   endtask

   task automatic write_csr(logic [7:0] idx, logic [31:0] wdata);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= wdata;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_SRC_ADDR:  shadow_cfg.src_addr  = wdata;
         REG_DST_ADDR:  shadow_cfg.dst_addr  = wdata;
         REG_SRC_PORT:  shadow_cfg.src_port  = wdata[15:0];
         REG_DEST_PORT: shadow_cfg.dest_port = wdata[15:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Holds requests back until the last header word has left the block.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_req(req_type r, bit known, hdr_type typed_hdr);
      hdr_type h;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, r};
      do @(posedge clock); while (!req_tready);
      h = known ? typed_hdr : predict_header(shadow_cfg, r);
      for (int k = 0; k < HdrWords; k++) begin
         words_due.push_back('{h[k], IdxWidth'(k), IdxWidth'(k) == LastIdx});
      end
   endtask

   always @(posedge clock) begin
      word_due_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (words_due.size() == 0) begin
            report_bad($sformatf("unexpected word %h index %0d last %b",
                                 rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            due = words_due.pop_front();
            if (rsp_tdata !== due.word || rsp_tuser !== due.idx ||
                rsp_tlast !== due.last) begin
               report_bad($sformatf(
                  "word mismatch: expected %h index %0d last %b, got %h index %0d last %b",
                  due.word, due.idx, due.last, rsp_tdata, rsp_tuser, rsp_tlast));
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      req_type r;
      add_known(6'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000, HdrBare);
      add_known(6'h3F, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000, HdrAllOnes);
      // An all-ones acknowledge base wraps to a zero acknowledge field.
      add_known(6'h00, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, HdrBare);
      add_req(6'h01, 16'h0001, 32'h0000_0001, 32'h0000_0001);
      add_req(6'h02, 16'h8000, 32'h8000_0000, 32'h7FFF_FFFF);
      add_req(6'h04, 16'h1234, 32'hDEAD_BEEF, 32'h0000_0000);
      add_req(6'h08, 16'h00FF, 32'h0000_FFFF, 32'hFFFF_0000);
      add_req(6'h10, 16'hFF00, 32'hFFFF_0000, 32'h0000_FFFF);
      add_req(6'h20, 16'h5A5A, 32'hA5A5_A5A5, 32'hFFFF_FFFE);
      add_cfg(REG_SRC_ADDR, 32'hFFFF_FFFF);
      add_cfg(REG_DST_ADDR, 32'hFFFF_FFFF);
      add_cfg(REG_SRC_PORT, 32'hFFFF_FFFF);
      add_cfg(REG_DEST_PORT, 32'hFFFF_FFFF);
      add_req(6'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
      add_req(6'h3F, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
      // Writes to indexes past the last register must leave the settings alone.
      add_cfg(8'h04, 32'h1234_5678);
      add_cfg(8'hFF, 32'h0000_0000);
      add_req(6'h12, 16'h4321, 32'h0000_0000, 32'h0000_0001);
      add_cfg(REG_SRC_ADDR, 32'hC0A8_0001);
      add_cfg(REG_DST_ADDR, 32'h0A00_0001);
      add_cfg(REG_SRC_PORT, 32'h0000_0050);
      add_cfg(REG_DEST_PORT, 32'h0000_C350);
      add_req(6'h02, 16'h0001, 32'h0000_0000, 32'h0000_0000);
      add_req(6'h12, 16'h0002, 32'h0000_0001, 32'hABCD_1234);
      add_req(6'h18, 16'hBEEF, 32'h7FFF_FFFF, 32'h8000_0000);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_CFG) begin
            wait_idle();
            write_csr(stim_table[i].csr_idx, stim_table[i].csr_wdata);
         end else begin
            send_req(stim_table[i].req, stim_table[i].known, stim_table[i].hdr);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 87 : 0;
         recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 11 : 0;
         wait_idle();
         write_csr(REG_SRC_ADDR, pick_cfg_value());
         write_csr(REG_DST_ADDR, pick_cfg_value());
         write_csr(REG_SRC_PORT, pick_cfg_value());
         write_csr(REG_DEST_PORT, pick_cfg_value());
         write_csr(8'($urandom_range(255, 4)), $urandom);
         for (int n = 0; n < 60; n++) begin
            if (n == 30) wait_idle();
            r.flags           = 6'($urandom);
            r.ip_ident        = 16'($urandom);
            r.sequence_number = $urandom;
            case ($urandom_range(7))
               0: r.ack_base = 32'd0;
               1: r.ack_base = 32'hFFFF_FFFF;
               default: r.ack_base = $urandom;
            endcase
            send_req(r, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && words_due.size() == 0) begin
         $display("ipv4_tcp_header_builder_unit_tb OK");
      end else begin
         $display("ipv4_tcp_header_builder_unit_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("ipv4_tcp_header_builder_unit_tb NOT OK");
      $finish;
   end

endmodule
